[design/htlsi_pkg.sv]
// Shared types, constants and helpers for the timer / LCD status / interrupt unit.
// No dependencies; used by every other file in the design folder.
package htlsi_pkg;

  // Register index map of the configuration write port
  localparam logic [2:0] RegTimerControl  = 3'd0;
  localparam logic [2:0] RegTimerModulo   = 3'd1;
  localparam logic [2:0] RegLcdEnable     = 3'd2;
  localparam logic [2:0] RegStatIrqEnable = 3'd3;
  localparam logic [2:0] RegIrqEnableMask = 3'd4;
  localparam logic [2:0] RegFramePeriod   = 3'd5;

  localparam int CfgDataWidth = 24;

  localparam logic [8:0]  DivLimit         = 9'd255;
  localparam logic [9:0]  LineCycles       = 10'd456;
  localparam logic [9:0]  Mode2Start       = 10'd376;
  localparam logic [9:0]  Mode3Start       = 10'd204;
  localparam logic [7:0]  LastLine         = 8'd153;
  localparam logic [7:0]  VblankLine       = 8'd144;
  localparam logic [11:0] TimerResetCount  = 12'd1024;
  localparam logic [23:0] FramePeriodReset = 24'd69905;
  localparam logic [24:0] DispatchCycles   = 25'd16;
  localparam logic [7:0]  TimaMax          = 8'd255;

  // LCD modes
  localparam logic [1:0] ModeHblank = 2'd0;
  localparam logic [1:0] ModeVblank = 2'd1;
  localparam logic [1:0] ModeOam    = 2'd2;
  localparam logic [1:0] ModeXfer   = 2'd3;

  // Interrupt flag bit positions
  localparam int IrqVblank = 0;
  localparam int IrqLcd    = 1;
  localparam int IrqTimer  = 2;
  localparam int IrqJoypad = 4;
  localparam int IrqCount  = 5;

  typedef struct packed {
    logic [2:0]  timer_control;
    logic [7:0]  timer_modulo;
    logic        lcd_enable;
    logic [1:0]  stat_irq_enables;
    logic [4:0]  irq_enable_mask;
    logic [23:0] frame_period;
  } cfg_t;

  typedef struct packed {
    logic [5:0] cycle_count;
    logic       master_enable;
    logic       joypad_request;
  } item_t;

  typedef struct packed {
    logic [7:0] divider_value;
    logic [7:0] timer_value;
    logic [7:0] line_number;
    logic [1:0] display_mode;
    logic [4:0] pending_flags;
    logic       dispatch;
    logic [6:0] vector_address;
  } result_t;

  // Timer reload for clock select bits
  function automatic logic [11:0] reload_for(input logic [1:0] sel);
    logic [11:0] r;
    unique case (sel)
      2'd1:    r = 12'd16;
      2'd2:    r = 12'd64;
      2'd3:    r = 12'd256;
      default: r = 12'd1024;
    endcase
    return r;
  endfunction

endpackage

[design/htlsi_core.sv]
// State registers and single-pass next-state logic: divider, LCD mode, scanline,
// timer, frame counter and interrupt dispatch. Depends on htlsi_pkg.
module htlsi_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  htlsi_pkg::item_t  item_i,
  input  htlsi_pkg::cfg_t   cfg_i,
  output htlsi_pkg::result_t result_o
);

  logic [8:0]  div_prescale_q, div_prescale_d;
  logic [7:0]  div_reg_q, div_reg_d;
  logic [9:0]  line_countdown_q, line_countdown_d;
  logic [7:0]  line_reg_q, line_reg_d;
  logic [1:0]  mode_reg_q, mode_reg_d;
  logic [11:0] timer_countdown_q, timer_countdown_d;
  logic [7:0]  tima_reg_q, tima_reg_d;
  logic [4:0]  irq_flags_q, irq_flags_d;
  logic [24:0] frame_count_q, frame_count_d;
  logic        taken;
  logic [6:0]  vector;

  always_comb begin
    logic [8:0] presc_sum;
    logic [1:0] next_mode;
    logic       req;
    logic [7:0] line_inc;
    logic [4:0] act;
    logic       found;

    irq_flags_d = irq_flags_q;
    if (item_i.joypad_request) begin
      irq_flags_d[htlsi_pkg::IrqJoypad] = 1'b1;
    end

    // divider
    presc_sum = div_prescale_q + {3'b0, item_i.cycle_count};
    if (presc_sum >= htlsi_pkg::DivLimit) begin
      div_prescale_d = '0;
      div_reg_d      = div_reg_q + 8'd1;
    end else begin
      div_prescale_d = presc_sum;
      div_reg_d      = div_reg_q;
    end

    // LCD mode and scanline
    next_mode = htlsi_pkg::ModeVblank;
    req       = 1'b0;
    line_inc  = line_reg_q + 8'd1;
    if (!cfg_i.lcd_enable) begin
      line_countdown_d = htlsi_pkg::LineCycles;
      line_reg_d       = '0;
      mode_reg_d       = htlsi_pkg::ModeVblank;
    end else begin
      priority if (line_reg_q >= htlsi_pkg::VblankLine) begin
        next_mode = htlsi_pkg::ModeVblank;
      end else if (line_countdown_q >= htlsi_pkg::Mode2Start) begin
        next_mode = htlsi_pkg::ModeOam;
        req       = cfg_i.stat_irq_enables[1];
      end else if (line_countdown_q >= htlsi_pkg::Mode3Start) begin
        next_mode = htlsi_pkg::ModeXfer;
      end else begin
        next_mode = htlsi_pkg::ModeHblank;
        req       = cfg_i.stat_irq_enables[0];
      end
      if (req && (next_mode != mode_reg_q)) begin
        irq_flags_d[htlsi_pkg::IrqLcd] = 1'b1;
      end
      mode_reg_d = next_mode;
      if (line_countdown_q <= {4'b0, item_i.cycle_count}) begin
        line_countdown_d = htlsi_pkg::LineCycles;
        line_reg_d       = (line_inc > htlsi_pkg::LastLine) ? 8'd0 : line_inc;
      end else begin
        line_countdown_d = line_countdown_q - {4'b0, item_i.cycle_count};
        line_reg_d       = line_reg_q;
      end
    end

    // programmable timer
    timer_countdown_d = timer_countdown_q;
    tima_reg_d        = tima_reg_q;
    if (cfg_i.timer_control[2]) begin
      if (timer_countdown_q <= {6'b0, item_i.cycle_count}) begin
        timer_countdown_d = htlsi_pkg::reload_for(cfg_i.timer_control[1:0]);
        if (tima_reg_q == htlsi_pkg::TimaMax) begin
          tima_reg_d                       = cfg_i.timer_modulo;
          irq_flags_d[htlsi_pkg::IrqTimer] = 1'b1;
        end else begin
          tima_reg_d = tima_reg_q + 8'd1;
        end
      end else begin
        timer_countdown_d = timer_countdown_q - {6'b0, item_i.cycle_count};
      end
    end

    // frame counter
    frame_count_d = frame_count_q + {19'b0, item_i.cycle_count};
    if (frame_count_d > {1'b0, cfg_i.frame_period}) begin
      irq_flags_d[htlsi_pkg::IrqVblank] = 1'b1;
      frame_count_d                     = '0;
    end

    // dispatch: lowest pending enabled request wins
    taken  = 1'b0;
    vector = '0;
    found  = 1'b0;
    act    = cfg_i.irq_enable_mask & irq_flags_d;
    if (item_i.master_enable) begin
      for (int b = 0; b < htlsi_pkg::IrqCount; b++) begin
        if (!found && act[b]) begin
          found          = 1'b1;
          irq_flags_d[b] = 1'b0;
          vector         = {1'b1, 3'(b), 3'b000};
        end
      end
      if (found) begin
        taken         = 1'b1;
        frame_count_d = frame_count_d + htlsi_pkg::DispatchCycles;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_prescale_q    <= '0;
      div_reg_q         <= '0;
      line_countdown_q  <= htlsi_pkg::LineCycles;
      line_reg_q        <= '0;
      mode_reg_q        <= htlsi_pkg::ModeHblank;
      timer_countdown_q <= htlsi_pkg::TimerResetCount;
      tima_reg_q        <= '0;
      irq_flags_q       <= '0;
      frame_count_q     <= '0;
    end else if (accept_i) begin
      div_prescale_q    <= div_prescale_d;
      div_reg_q         <= div_reg_d;
      line_countdown_q  <= line_countdown_d;
      line_reg_q        <= line_reg_d;
      mode_reg_q        <= mode_reg_d;
      timer_countdown_q <= timer_countdown_d;
      tima_reg_q        <= tima_reg_d;
      irq_flags_q       <= irq_flags_d;
      frame_count_q     <= frame_count_d;
    end
  end

  assign result_o.divider_value  = div_reg_d;
  assign result_o.timer_value    = tima_reg_d;
  assign result_o.line_number    = line_reg_d;
  assign result_o.display_mode   = mode_reg_d;
  assign result_o.pending_flags  = irq_flags_d;
  assign result_o.dispatch       = taken;
  assign result_o.vector_address = vector;

endmodule

[design/htlsi_outreg.sv]
// Result register with valid/stall handshake; frees the input side whenever the
// held request is taken or absent. Depends on htlsi_pkg.
module htlsi_outreg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  htlsi_pkg::result_t result_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htlsi_pkg::result_t result_o,
  output logic               accept_o
);

  logic               valid_q, valid_d;
  htlsi_pkg::result_t data_q;

  assign in_stall_o = valid_q && out_stall_i;
  assign accept_o   = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

[design/handheld_timer_lcd_status_irq_unit.sv]
// Top level of the timer / LCD status / interrupt unit: configuration registers,
// core and result register. Depends on htlsi_pkg, htlsi_core and htlsi_outreg.

// One request per executed instruction: its cycle count, the CPU master enable
// and a joypad request. The block advances the divider, LCD mode and scanline,
// the programmable timer and the frame counter, then dispatches the lowest
// pending enabled interrupt and reports all register values. Throughput is one
// request per clock while not stalled; the result reaches the output register
// in the cycle after acceptance, through a single pass of add/compare logic
// from the state registers. A held result does not block acceptance unless it
// is stalled. Configuration is written through a plain write port; the user
// must write it only while the block is idle, which the block does not enforce.
module handheld_timer_lcd_status_irq_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [htlsi_pkg::CfgDataWidth-1:0] cfg_data_i,
  // input request
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  cycle_count_i,
  input  logic        master_enable_i,
  input  logic        joypad_request_i,
  // result request
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  divider_value_o,
  output logic [7:0]  timer_value_o,
  output logic [7:0]  line_number_o,
  output logic [1:0]  display_mode_o,
  output logic [4:0]  pending_flags_o,
  output logic        dispatch_o,
  output logic [6:0]  vector_address_o
);

  htlsi_pkg::cfg_t    cfg_q;
  htlsi_pkg::item_t   item;
  htlsi_pkg::result_t core_result;
  htlsi_pkg::result_t out_result;
  logic               accept;

  // Configuration registers; unused indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_control    <= '0;
      cfg_q.timer_modulo     <= '0;
      cfg_q.lcd_enable       <= 1'b0;
      cfg_q.stat_irq_enables <= '0;
      cfg_q.irq_enable_mask  <= '0;
      cfg_q.frame_period     <= htlsi_pkg::FramePeriodReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        htlsi_pkg::RegTimerControl:  cfg_q.timer_control    <= cfg_data_i[2:0];
        htlsi_pkg::RegTimerModulo:   cfg_q.timer_modulo     <= cfg_data_i[7:0];
        htlsi_pkg::RegLcdEnable:     cfg_q.lcd_enable       <= cfg_data_i[0];
        htlsi_pkg::RegStatIrqEnable: cfg_q.stat_irq_enables <= cfg_data_i[1:0];
        htlsi_pkg::RegIrqEnableMask: cfg_q.irq_enable_mask  <= cfg_data_i[4:0];
        htlsi_pkg::RegFramePeriod:   cfg_q.frame_period     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item.cycle_count    = cycle_count_i;
  assign item.master_enable  = master_enable_i;
  assign item.joypad_request = joypad_request_i;

  // State update happens at the same edge as the result is captured
  htlsi_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (core_result)
  );

  htlsi_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (core_result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result),
    .accept_o    (accept)
  );

  assign divider_value_o  = out_result.divider_value;
  assign timer_value_o    = out_result.timer_value;
  assign line_number_o    = out_result.line_number;
  assign display_mode_o   = out_result.display_mode;
  assign pending_flags_o  = out_result.pending_flags;
  assign dispatch_o       = out_result.dispatch;
  assign vector_address_o = out_result.vector_address;

  // An accepted request always produces a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request lost");

  // Scanline never leaves its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_number_o <= htlsi_pkg::LastLine))
    else $error("scanline out of range");

  // Vector is well formed when taken and zero otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dispatch_o ? (vector_address_o[6] && vector_address_o[2:0] == 3'd0
                                   && vector_address_o[5:3] <= 3'd4)
                                : (vector_address_o == 7'd0)))
    else $error("bad interrupt vector");

endmodule
